// ===== hdl/sau_pkg.sv =====
// Shared types, constants and helpers for the SGD/Adam parameter update block.
`default_nettype none
package sau_pkg;

   localparam int MAX_ELEMENTS_DEF = 4096;

   // Field widths
   localparam int DATA_W    = 32;
   localparam int INDEX_W   = 12;
   localparam int FRAC_W    = 24;
   localparam int POW_W     = 25;
   localparam int MOM2_W    = 48;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EPS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY = 3'd5;

   // Register reset values
   localparam logic [23:0] LR_RST    = 24'd16777;
   localparam logic [23:0] BETA1_RST = 24'd15099494;
   localparam logic [23:0] BETA2_RST = 24'd16760439;
   localparam logic [31:0] EPS_RST   = 32'd43;
   localparam logic [23:0] DECAY_RST = 24'd0;

   localparam logic [POW_W-1:0] POW_ONE = 25'd16777216;

   // Bit-serial multiplier: 48 x 32 unsigned, one multiplier bit per cycle
   localparam int MUL_A_W     = 48;
   localparam int MUL_B_W     = 32;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W   = 6;
   localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 6'd32;

   // Restoring divider: one quotient bit per cycle
   localparam int DIV_R_W   = 49;
   localparam int DIV_N_W   = 72;
   localparam int DIV_CNT_W = 7;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FULL = 7'd72;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_FRAC = 7'd24;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_R_W-1:0]   rem_init;
      logic [DIV_N_W-1:0]   dividend;
      logic [DIV_R_W-1:0]   divisor;
      logic [DIV_CNT_W-1:0] steps;
   } div_req_type;

   function automatic logic [31:0] abs32(input logic signed [31:0] x);
      return x[31] ? 32'(-x) : 32'(x);
   endfunction

   function automatic logic [31:0] sat32(input logic signed [33:0] x);
      if (x > 34'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (x < -34'sd2147483648) begin
         return 32'h8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic logic sat32_hit(input logic signed [33:0] x);
      return (x > 34'sd2147483647) || (x < -34'sd2147483648);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/sgd_adam_param_update.sv =====
// Top level: per-element SGD / Adam parameter update in Q8.24 fixed point.
// Adam skips a bias-correction division while its bias power is still one, and the update
//   division when m_hat is zero or the update clamps to one; step_start adds the power updates.
// Throughput: one word at a time; the next word is taken the cycle after the current one has
//   moved to the output register. The rate is set by the shared bit-serial multiplier,
//   the divider (one quotient bit per cycle) and the root loop.
// Reset: synchronous; a clearing pass over all MAX_ELEMENTS entries zeroes the moment store,
//   and req_ready stays low until it ends. Configuration writes are taken throughout.
`default_nettype none
module sgd_adam_param_update #(
   parameter int MAX_ELEMENTS = sau_pkg::MAX_ELEMENTS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input words
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [sau_pkg::INDEX_W-1:0]         req_element_index,
   input  wire logic signed [sau_pkg::DATA_W-1:0]   req_param_value,
   input  wire logic signed [sau_pkg::DATA_W-1:0]   req_gradient,
   input  wire logic                                req_step_start,
   // result words
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [sau_pkg::DATA_W-1:0]        rsp_new_param_value,
   output logic                                     rsp_saturated,
   // configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sau_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [31:0]                         csr_data
);
   import sau_pkg::*;

   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam logic [IDX_W:0]   MAX_C   = (IDX_W+1)'(MAX_ELEMENTS);
   localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(MAX_ELEMENTS - 1);
   localparam logic [3:0]       RED_STEPS = 4'(INDEX_W);

   // Sequencer: one-hot, one state per arithmetic step
   typedef enum logic [19:0] {
      ST_CLEAR  = 20'h00001,
      ST_IDLE   = 20'h00002,
      ST_POW1   = 20'h00004,
      ST_POW2   = 20'h00008,
      ST_DECAY  = 20'h00010,
      ST_GRAD   = 20'h00020,
      ST_SGD    = 20'h00040,
      ST_MREAD  = 20'h00080,
      ST_M1     = 20'h00100,
      ST_M2     = 20'h00200,
      ST_SQ     = 20'h00400,
      ST_V1     = 20'h00800,
      ST_V2     = 20'h01000,
      ST_MWRITE = 20'h02000,
      ST_DIV1   = 20'h04000,
      ST_DIV2   = 20'h08000,
      ST_ROOT   = 20'h10000,
      ST_UDIV   = 20'h20000,
      ST_LRMUL  = 20'h40000,
      ST_FINISH = 20'h80000
   } state_type;

   state_type state_ff, state_in;
   logic      launch_ff;

   // configuration registers
   logic        mode_ff;
   logic [23:0] lr_ff, b1_ff, b2_ff, dw_ff;
   logic [31:0] eps_ff;

   // bias powers
   logic [POW_W-1:0] p1_ff, p2_ff;

   // index reduction modulo MAX_ELEMENTS, one bit a cycle
   logic [INDEX_W-1:0] raw_ff;
   logic [IDX_W-1:0]   red_ff;
   logic [3:0]         red_cnt_ff;
   logic [IDX_W:0]     red_sh;

   // clearing pass
   logic [IDX_W-1:0] clr_cnt_ff;

   // moment store
   logic [DATA_W-1:0] fm_mem [MAX_ELEMENTS];
   logic [MOM2_W-1:0] sm_mem [MAX_ELEMENTS];
   logic signed [DATA_W-1:0] m_rd_ff;
   logic [MOM2_W-1:0]        v_rd_ff;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_wa;
   logic [DATA_W-1:0]        mem_wd_m;
   logic [MOM2_W-1:0]        mem_wd_v;

   // datapath
   logic signed [DATA_W-1:0] p_ff, graw_ff, g_ff, m_new_ff;
   logic signed [80:0]       sprod_ff, acc_ff, pair_sum;
   logic [MOM2_W-1:0]        s_ff, v_new;
   logic [MOM2_W-1:0]        v_hold_ff;   // second moment as written back, held for the bias correction
   logic [63:0]              mh_ff, vh_ff, ua;
   logic [DIV_R_W-1:0]       den_ff;
   logic [POW_W-1:0]         u_ff;
   logic signed [DATA_W-1:0] clip;
   logic signed [33:0]       gsum, diff;
   logic [POW_W-1:0]         d1, d2, c1, c2;
   logic [31:0]              am;

   // root loop
   logic [63:0] sq_rad_ff;
   logic [33:0] sq_rem_ff;
   logic [31:0] sq_root_ff;
   logic [5:0]  sq_cnt_ff;
   logic        sq_small_ff;
   logic [35:0] sq_rem_sh, sq_trial;
   logic        sq_fits;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] out_ff;
   logic                     out_sat_ff;
   logic                     out_take;

   // arithmetic units
   mul_req_type        mul_req;
   logic               mul_done;
   logic [MUL_P_W-1:0] mul_prod;
   logic               mul_neg;
   div_req_type        div_req;
   logic               div_done;
   logic [DIV_N_W-1:0] div_quot;

   logic req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_take  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign d1 = POW_ONE - p1_ff;
   assign d2 = POW_ONE - p2_ff;
   assign c1 = POW_ONE - POW_W'(b1_ff);
   assign c2 = POW_ONE - POW_W'(b2_ff);
   assign am = abs32(m_new_ff);
   assign ua = {mh_ff[55:0], 8'b0};

   // weighted sum of the two products of a moment update
   assign pair_sum = acc_ff + sprod_ff;
   assign v_new    = pair_sum[71:24];

   // decayed gradient: gradient + floor(decay * param / 2^24)
   assign gsum = 34'(graw_ff) + 34'($signed(sprod_ff[57:24]));
   // new value: param - floor(lr * update / 2^24)
   assign diff = 34'(p_ff) - 34'($signed(sprod_ff[50:24]));

   // SGD gradient clip to plus or minus one
   always_comb begin
      if (g_ff > $signed(32'(POW_ONE))) begin
         clip = $signed(32'(POW_ONE));
      end else if (g_ff < -$signed(32'(POW_ONE))) begin
         clip = -$signed(32'(POW_ONE));
      end else begin
         clip = g_ff;
      end
   end

   assign red_sh = {red_ff, raw_ff[INDEX_W-1]};

   assign sq_rem_sh = {sq_rem_ff, sq_rad_ff[63:62]};
   assign sq_trial  = {2'b00, sq_root_ff, 2'b01};
   assign sq_fits   = sq_rem_sh >= sq_trial;

   // Multiplier operand select: magnitudes in, sign applied on capture
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;
      mul_neg       = 1'b0;
      case (state_ff)
         ST_POW1: begin
            mul_req.a = MUL_A_W'(p1_ff);
            mul_req.b = MUL_B_W'(b1_ff);
         end
         ST_POW2: begin
            mul_req.a = MUL_A_W'(p2_ff);
            mul_req.b = MUL_B_W'(b2_ff);
         end
         ST_DECAY: begin
            mul_req.a = MUL_A_W'(abs32(p_ff));
            mul_req.b = MUL_B_W'(dw_ff);
            mul_neg   = p_ff[31];
         end
         ST_SGD: begin
            mul_req.a = MUL_A_W'(abs32(clip));
            mul_req.b = MUL_B_W'(lr_ff);
            mul_neg   = clip[31];
         end
         ST_M1: begin
            mul_req.a = MUL_A_W'(abs32(m_rd_ff));
            mul_req.b = MUL_B_W'(b1_ff);
            mul_neg   = m_rd_ff[31];
         end
         ST_M2: begin
            mul_req.a = MUL_A_W'(abs32(g_ff));
            mul_req.b = MUL_B_W'(c1);
            mul_neg   = g_ff[31];
         end
         ST_SQ: begin
            mul_req.a = MUL_A_W'(abs32(g_ff));
            mul_req.b = abs32(g_ff);
         end
         ST_V1: begin
            mul_req.a = v_rd_ff;
            mul_req.b = MUL_B_W'(b2_ff);
         end
         ST_V2: begin
            mul_req.a = s_ff;
            mul_req.b = MUL_B_W'(c2);
         end
         ST_LRMUL: begin
            mul_req.a = MUL_A_W'(u_ff);
            mul_req.b = MUL_B_W'(lr_ff);
            mul_neg   = m_new_ff[31];
         end
         default: begin
         end
      endcase
      mul_req.start = launch_ff && (state_ff inside {ST_POW1, ST_POW2, ST_DECAY, ST_SGD,
                                                     ST_M1, ST_M2, ST_SQ, ST_V1, ST_V2,
                                                     ST_LRMUL});
   end

   // Divider operand select; a zero bias correction or a trivial update skips it
   always_comb begin
      div_req.start    = 1'b0;
      div_req.rem_init = '0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      div_req.steps    = DIV_STEPS_FULL;
      case (state_ff)
         ST_DIV1: begin
            div_req.dividend = {16'b0, am, 24'b0};
            div_req.divisor  = DIV_R_W'(d1);
            div_req.start    = launch_ff && (d1 != '0);
         end
         ST_DIV2: begin
            div_req.dividend = {v_hold_ff, 24'b0};
            div_req.divisor  = DIV_R_W'(d2);
            div_req.start    = launch_ff && (d2 != '0);
         end
         ST_UDIV: begin
            div_req.rem_init = ua[DIV_R_W-1:0];
            div_req.divisor  = den_ff;
            div_req.steps    = DIV_STEPS_FRAC;
            div_req.start    = launch_ff && (mh_ff != '0) && (ua < 64'(den_ff));
         end
         default: begin
         end
      endcase
   end

   sau_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   sau_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_IX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) state_in = req_step_start ? ST_POW1 : ST_DECAY;
         end
         ST_POW1:  if (mul_done) state_in = ST_POW2;
         ST_POW2:  if (mul_done) state_in = ST_DECAY;
         ST_DECAY: if (mul_done) state_in = ST_GRAD;
         ST_GRAD:  state_in = mode_ff ? ST_MREAD : ST_SGD;
         ST_SGD:   if (mul_done) state_in = ST_FINISH;
         ST_MREAD: state_in = ST_M1;
         ST_M1:    if (mul_done) state_in = ST_M2;
         ST_M2:    if (mul_done) state_in = ST_SQ;
         ST_SQ:    if (mul_done) state_in = ST_V1;
         ST_V1:    if (mul_done) state_in = ST_V2;
         ST_V2:    if (mul_done) state_in = ST_MWRITE;
         ST_MWRITE: state_in = ST_DIV1;
         ST_DIV1: begin
            if ((launch_ff && d1 == '0) || div_done) state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if ((launch_ff && d2 == '0) || div_done) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (!launch_ff && sq_cnt_ff == '0) state_in = ST_UDIV;
         end
         ST_UDIV: begin
            if ((launch_ff && !div_req.start) || div_done) state_in = ST_LRMUL;
         end
         ST_LRMUL: if (mul_done) state_in = ST_FINISH;
         ST_FINISH: if (out_take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_cnt_ff   <= '0;
         red_cnt_ff   <= '0;
         sq_cnt_ff    <= '0;
         p1_ff        <= POW_ONE;
         p2_ff        <= POW_ONE;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= (state_in != state_ff);
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (req_take) begin
            red_cnt_ff <= RED_STEPS;
         end else if (red_cnt_ff != '0) begin
            red_cnt_ff <= red_cnt_ff - 1'b1;
         end
         if (state_ff == ST_ROOT) begin
            if (launch_ff) begin
               sq_cnt_ff <= 6'd32;
            end else if (sq_cnt_ff != '0) begin
               sq_cnt_ff <= sq_cnt_ff - 1'b1;
            end
         end
         // advance the bias powers when a step opens
         if (mul_done && state_ff == ST_POW1) p1_ff <= mul_prod[48:24];
         if (mul_done && state_ff == ST_POW2) p2_ff <= mul_prod[48:24];
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         lr_ff   <= LR_RST;
         b1_ff   <= BETA1_RST;
         b2_ff   <= BETA2_RST;
         eps_ff  <= EPS_RST;
         dw_ff   <= DECAY_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:  mode_ff <= csr_data[0];
            CSR_LR:    lr_ff   <= csr_data[23:0];
            CSR_BETA1: b1_ff   <= csr_data[23:0];
            CSR_BETA2: b2_ff   <= csr_data[23:0];
            CSR_EPS:   eps_ff  <= csr_data;
            CSR_DECAY: dw_ff   <= csr_data[23:0];
            default: begin
            end
         endcase
      end
   end

   // Moment store: zero sweep after reset, write-back after the moment update
   assign mem_we   = (state_ff == ST_CLEAR) || (state_ff == ST_MWRITE);
   assign mem_wa   = (state_ff == ST_CLEAR) ? clr_cnt_ff : red_ff;
   assign mem_wd_m = (state_ff == ST_CLEAR) ? '0 : m_new_ff;
   assign mem_wd_v = (state_ff == ST_CLEAR) ? '0 : v_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fm_mem[mem_wa] <= mem_wd_m;
         sm_mem[mem_wa] <= mem_wd_v;
      end
      if (state_ff == ST_MREAD) begin
         m_rd_ff <= fm_mem[red_ff];
         v_rd_ff <= sm_mem[red_ff];
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         p_ff    <= req_param_value;
         graw_ff <= req_gradient;
         raw_ff  <= req_element_index;
         red_ff  <= '0;
      end else if (red_cnt_ff != '0) begin
         raw_ff <= {raw_ff[INDEX_W-2:0], 1'b0};
         red_ff <= (red_sh >= MAX_C) ? IDX_W'(red_sh - MAX_C) : IDX_W'(red_sh);
      end

      // capture every product with its sign applied
      if (mul_done) begin
         sprod_ff <= mul_neg ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
      end

      if (state_ff == ST_GRAD) g_ff <= $signed(sat32(gsum));

      // first cycle of a state consumes the previous product, presets a skip or starts the root loop
      if (launch_ff) begin
         case (state_ff)
            ST_M2:  acc_ff   <= sprod_ff;
            ST_SQ:  m_new_ff <= $signed(pair_sum[55:24]);
            ST_V1:  s_ff     <= sprod_ff[63:16];
            ST_V2:  acc_ff   <= sprod_ff;
            ST_DIV1: if (d1 == '0) mh_ff <= 64'(am);
            ST_DIV2: if (d2 == '0) vh_ff <= 64'(v_hold_ff);
            ST_ROOT: begin
               sq_small_ff <= (vh_ff[63:32] == '0);
               sq_rad_ff   <= (vh_ff[63:32] == '0) ? {vh_ff[31:0], 32'b0} : vh_ff;
               sq_rem_ff   <= '0;
               sq_root_ff  <= '0;
            end
            ST_UDIV: begin
               if (mh_ff == '0) begin
                  u_ff <= '0;
               end else if (ua >= 64'(den_ff)) begin
                  u_ff <= POW_ONE;
               end
            end
            default: begin
            end
         endcase
      end

      if (state_ff == ST_MWRITE) v_hold_ff <= v_new;

      if (div_done) begin
         case (state_ff)
            ST_DIV1: mh_ff <= div_quot[63:0];
            ST_DIV2: vh_ff <= (div_quot[71:64] != '0) ? '1 : div_quot[63:0];
            ST_UDIV: u_ff  <= div_quot[POW_W-1:0];
            default: begin
            end
         endcase
      end

      // root: two radicand bits a cycle, then add the guard
      if (state_ff == ST_ROOT && !launch_ff) begin
         if (sq_cnt_ff != '0) begin
            sq_rad_ff  <= {sq_rad_ff[61:0], 2'b00};
            sq_rem_ff  <= sq_fits ? 34'(sq_rem_sh - sq_trial) : 34'(sq_rem_sh);
            sq_root_ff <= {sq_root_ff[30:0], sq_fits};
         end else begin
            den_ff <= (sq_small_ff ? DIV_R_W'(sq_root_ff) : {1'b0, sq_root_ff, 16'b0})
                      + DIV_R_W'(eps_ff);
         end
      end

      if (out_take) begin
         out_ff     <= $signed(sat32(diff));
         out_sat_ff <= sat32_hit(diff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_new_param_value = out_ff;
   assign rsp_saturated       = out_sat_ff;

   // the reduced index is settled before the store is read
   a_index_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MREAD) |-> (red_cnt_ff == '0 && {1'b0, red_ff} < MAX_C))
      else $error("moment index not reduced before read");

   // bias powers only decay from one
   a_pow_range: assert property (@(posedge clock) disable iff (reset)
      (p1_ff <= POW_ONE) && (p2_ff <= POW_ONE))
      else $error("bias power above one");

   // the shared units never finish together
   a_unit_excl: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");

   // a finished word lands in the output register and frees the input side
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_take |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded");

endmodule
`default_nettype wire

// ===== hdl/sau_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module sau_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sau_pkg::mul_req_type          req,
   output logic                               done,
   output logic [sau_pkg::MUL_P_W-1:0]        prod
);
   import sau_pkg::*;

   logic [MUL_A_W-1:0]   a_ff;
   logic [MUL_A_W-1:0]   hi_ff;
   logic [MUL_B_W-1:0]   lo_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [MUL_A_W:0]     sum;

   // add the multiplicand when the low multiplier bit is set
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MUL_STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == MUL_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff  <= req.a;
         hi_ff <= '0;
         lo_ff <= req.b;
      end else if (busy_ff) begin
         hi_ff <= sum[MUL_A_W:1];
         lo_ff <= {sum[0], lo_ff[MUL_B_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule
`default_nettype wire

// ===== hdl/sau_div.sv =====
// Restoring divider, one quotient bit per cycle, with a preset partial remainder.
`default_nettype none
module sau_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sau_pkg::div_req_type          req,
   output logic                               done,
   output logic [sau_pkg::DIV_N_W-1:0]        quot
);
   import sau_pkg::*;

   logic [DIV_R_W-1:0]   rem_ff;
   logic [DIV_R_W-1:0]   dvs_ff;
   logic [DIV_N_W-1:0]   dvd_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_R_W:0]     rem_sh;
   logic                 fits;

   assign rem_sh = {rem_ff, dvd_ff[DIV_N_W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // quotient bits enter at the bottom as dividend bits leave at the top
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.rem_init;
         dvs_ff <= req.divisor;
         dvd_ff <= req.dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? DIV_R_W'(rem_sh - {1'b0, dvs_ff}) : DIV_R_W'(rem_sh);
         dvd_ff <= {dvd_ff[DIV_N_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = dvd_ff;

endmodule
`default_nettype wire

// ===== tb/sv/tb_sgd_adam_param_update.sv =====
// Testbench for sgd_adam_param_update: directed and random words checked against a local predictor.
module tb_sgd_adam_param_update;
   import sau_pkg::*;

   // Indexes past the register list; the block must ignore writes to them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam longint ONE_Q24 = 64'sd16777216;
   localparam longint INT32_MAX = 64'sd2147483647;
   localparam longint INT32_MIN = -64'sd2147483648;
   localparam int IDLE_LIMIT = 20000;   // clearing pass + long receiver stall + margin
   localparam int DRAIN_CYCLES = 600;   // covers the worst Adam latency with a step start

   typedef struct {
      logic signed [31:0] value;
      logic               sat;
   } param_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [INDEX_W-1:0] req_element_index = '0;
   logic signed [DATA_W-1:0] req_param_value = '0;
   logic signed [DATA_W-1:0] req_gradient = '0;
   logic req_step_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_new_param_value;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // Shadow copy of the configuration and the optimizer state
   logic        cfg_mode;
   logic [23:0] cfg_lr, cfg_beta1, cfg_beta2, cfg_decay;
   logic [31:0] cfg_eps;
   logic signed [31:0] first_mom [MAX_ELEMENTS_DEF];
   logic [47:0] second_mom [MAX_ELEMENTS_DEF];
   longint unsigned pow_beta1, pow_beta2;

   param_result_type expected_updates[$];
   int errors = 0;
   int idle_cycles = 0;
   int rsp_hold = 0;    // receiver hold-off length requested by the pressure test
   bit quiet = 1'b0;    // no random idling on either side while set

   sgd_adam_param_update u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_element_index(req_element_index), .req_param_value(req_param_value),
      .req_gradient(req_gradient), .req_step_start(req_step_start),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_param_value(rsp_new_param_value), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Compute the updated parameter for one word and advance the shadow state
   function automatic param_result_type predict_update(int unsigned idx,
                                                       logic signed [31:0] pv,
                                                       logic signed [31:0] gv, logic ss);
      longint p, g, c, m, su, delta, np;
      longint unsigned ag, s, d1, d2, am, mh, vh, root, den, u, a;
      logic [127:0] w;
      logic [47:0] v;
      param_result_type r;
      p = pv;
      g = gv;
      // a step start advances both bias powers before this word
      if (ss) begin
         pow_beta1 = (pow_beta1 * cfg_beta1) >> 24;
         pow_beta2 = (pow_beta2 * cfg_beta2) >> 24;
      end
      g = g + ((longint'(cfg_decay) * p) >>> 24);
      if (g > INT32_MAX) g = INT32_MAX;
      if (g < INT32_MIN) g = INT32_MIN;
      if (cfg_mode == 1'b0) begin
         // plain SGD: clip the gradient to +-1.0
         c = g > ONE_Q24 ? ONE_Q24 : (g < -ONE_Q24 ? -ONE_Q24 : g);
         delta = (longint'(cfg_lr) * c) >>> 24;
      end else begin
         m = first_mom[idx];
         v = second_mom[idx];
         ag = g < 0 ? -g : g;
         s = (ag * ag) >> 16;
         d1 = ONE_Q24 - pow_beta1;
         d2 = ONE_Q24 - pow_beta2;
         m = (longint'(cfg_beta1) * m + (ONE_Q24 - longint'(cfg_beta1)) * g) >>> 24;
         w = (128'(cfg_beta2) * v + (128'(ONE_Q24) - 128'(cfg_beta2)) * 128'(s)) >> 24;
         v = w[47:0];
         first_mom[idx] = m[31:0];
         second_mom[idx] = v;
         // bias correction is skipped while a power is still exactly one
         am = m < 0 ? -m : m;
         mh = d1 == 0 ? am : (am << 24) / d1;
         if (d2 == 0) begin
            vh = v;
         end else begin
            w = (128'(v) << 24) / 128'(d2);
            vh = w[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : w[63:0];
         end
         root = vh < 64'h1_0000_0000 ? int_sqrt(vh << 32) : int_sqrt(vh) << 16;
         den = root + cfg_eps;
         // zero denominator with nonzero m_hat clamps to 1.0
         if (mh == 0) begin
            u = 0;
         end else begin
            a = mh << 8;
            if (a >= den) begin
               u = ONE_Q24;
            end else begin
               w = (128'(a) << 24) / 128'(den);
               u = w[63:0];
            end
         end
         su = m < 0 ? -longint'(u) : longint'(u);
         delta = (longint'(cfg_lr) * su) >>> 24;
      end
      np = p - delta;
      r.sat = (np > INT32_MAX) || (np < INT32_MIN);
      if (np > INT32_MAX) np = INT32_MAX;
      if (np < INT32_MIN) np = INT32_MIN;
      r.value = np[31:0];
      return r;
   endfunction

   function automatic int pick_gap();
      if (quiet) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 2);
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   // Offer one word, hold it until taken, then record its expected result
   task automatic send_word(int unsigned idx, logic signed [31:0] pv, logic signed [31:0] gv,
                            logic ss);
      int gap;
      param_result_type want;
      gap = pick_gap();
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element_index <= idx[INDEX_W-1:0];
      req_param_value <= pv;
      req_gradient <= gv;
      req_step_start <= ss;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = predict_update(idx, pv, gv, ss);
      expected_updates.insert(expected_updates.size(), want);
   endtask

   // Write one register once every result is back; the block is then idle
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      req_valid <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MODE:  cfg_mode = data[0];
         CSR_LR:    cfg_lr = data[23:0];
         CSR_BETA1: cfg_beta1 = data[23:0];
         CSR_BETA2: cfg_beta2 = data[23:0];
         CSR_EPS:   cfg_eps = data;
         CSR_DECAY: cfg_decay = data[23:0];
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] rand_q824();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
   endfunction

   task automatic send_random(bit reuse);
      int unsigned idx;
      idx = (reuse && $urandom_range(0, 3) != 0) ? $urandom_range(0, 7)
                                                 : $urandom_range(0, 4095);
      send_word(idx, rand_q824(), rand_q824(), $urandom_range(0, 15) == 0);
   endtask

   function automatic logic [23:0] rand_beta();
      case ($urandom_range(0, 3))
         0: return 24'hFFFFFF;
         1: return BETA1_RST;
         2: return BETA2_RST;
         default: return $urandom_range(0, 24'hFFFFFF);
      endcase
   endfunction

   // Adam before any step opened: both corrections skipped, zero-denominator paths
   task automatic test_adam_before_step();
      csr_write(CSR_MODE, 32'd1);
      csr_write(CSR_EPS, 32'd0);
      send_word(10, 32'sd0, 32'sd0, 1'b0);
      send_word(11, 32'sd0, 32'sd255, 1'b0);
      send_word(12, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
      send_word(13, 32'sh80000000, 32'sh80000000, 1'b0);
      send_word(12, 32'sd5, -32'sd1000000, 1'b0);
      csr_write(CSR_EPS, 32'hFFFFFFFF);
      send_word(14, 32'sd0, 32'sh01000000, 1'b0);
      send_word(4095, -32'sd7, 32'sh00123456, 1'b0);
   endtask

   // SGD extremes: clipping on both sides, saturation, learning rate ends, step starts
   task automatic test_sgd_directed();
      csr_write(CSR_MODE, 32'd0);
      csr_write(CSR_EPS, 32'(EPS_RST));
      csr_write(CSR_LR, 32'hFFFFFF);
      send_word(0, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
      send_word(4095, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
      send_word(1, 32'sd0, 32'sh01000001, 1'b0);
      send_word(2, 32'sd0, -32'sh01000001, 1'b1);
      send_word(3, 32'sd100, 32'sh00FFFFFF, 1'b0);
      csr_write(CSR_DECAY, 32'hFFFFFF);
      send_word(4, 32'sh80000000, 32'sd0, 1'b0);
      send_word(5, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
      csr_write(CSR_LR, 32'd0);
      send_word(6, 32'sh12345678, -32'sd1, 1'b0);
   endtask

   task automatic test_sgd_random();
      repeat (3) begin
         csr_write(CSR_LR, $urandom_range(0, 24'hFFFFFF));
         csr_write(CSR_DECAY, $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 24'hFFFFFF));
         repeat (50) send_random(1'b0);
      end
   endtask

   // Beta extremes: zero powers after one step, powers that barely move
   task automatic test_adam_betas();
      csr_write(CSR_MODE, 32'd1);
      csr_write(CSR_DECAY, 32'd0);
      csr_write(CSR_LR, 32'(LR_RST));
      csr_write(CSR_BETA1, 32'd0);
      csr_write(CSR_BETA2, 32'd0);
      send_word(20, 32'sd0, 32'sh00400000, 1'b1);
      send_word(21, 32'sd1, -32'sh00400000, 1'b0);
      csr_write(CSR_BETA1, 32'hFFFFFF);
      csr_write(CSR_BETA2, 32'hFFFFFF);
      send_word(20, 32'sd0, 32'sh00010000, 1'b1);
      send_word(22, 32'sd0, 32'sh7FFFFFFF, 1'b1);
   endtask

   task automatic test_adam_random();
      repeat (4) begin
         csr_write(CSR_BETA1, rand_beta());
         csr_write(CSR_BETA2, rand_beta());
         csr_write(CSR_LR, $urandom_range(0, 24'hFFFFFF));
         csr_write(CSR_EPS, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255));
         csr_write(CSR_DECAY, $urandom_range(0, 2) == 0 ? $urandom_range(0, 24'hFFFFFF) : 0);
         quiet = $urandom_range(0, 3) == 0;
         repeat (90) send_random(1'b1);
         quiet = 1'b0;
      end
   endtask

   // Writes past the register list must leave the settings alone
   task automatic test_spare_index();
      csr_write(CSR_SPARE_LO, 32'hFFFFFFFF);
      csr_write(CSR_SPARE_HI, 32'h0);
      repeat (4) send_random(1'b1);
   endtask

   // Hold the receiver off long enough that the block fills and stalls its input
   task automatic test_backpressure();
      rsp_hold = 3000;
      quiet = 1'b1;
      repeat (8) send_random(1'b1);
      quiet = 1'b0;
   endtask

   // Receiver: random stalls, or one long hold-off when asked
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (rsp_hold != 0) begin
            rsp_ready <= 1'b0;
            n = rsp_hold;
            rsp_hold = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = pick_gap() + 1;
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 20);
         end
         repeat (n - 1) @(posedge clock);
      end
   end

   // Check each result word against the oldest expectation
   always @(posedge clock) begin
      param_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_updates.size() == 0) begin
            report_mismatch("unexpected word", rsp_new_param_value, 0);
         end else begin
            want = expected_updates.pop_front();
            if (rsp_new_param_value !== want.value)
               report_mismatch("new_param_value", rsp_new_param_value, want.value);
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", rsp_saturated, want.sat);
         end
      end
   end

   // Watchdog: end the run when no channel has moved for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      cfg_mode = 1'b0;
      cfg_lr = LR_RST;
      cfg_beta1 = BETA1_RST;
      cfg_beta2 = BETA2_RST;
      cfg_eps = EPS_RST;
      cfg_decay = DECAY_RST;
      pow_beta1 = ONE_Q24;
      pow_beta2 = ONE_Q24;
      for (int i = 0; i < MAX_ELEMENTS_DEF; i++) begin
         first_mom[i] = '0;
         second_mom[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_adam_before_step();
      test_sgd_directed();
      test_sgd_random();
      test_adam_betas();
      test_adam_random();
      test_spare_index();
      test_backpressure();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
